FILE: hw/rtl/btf_pkg.sv
// Shared types and constants of the background tile fetcher.
package btf_pkg;

    localparam int VRAM_BYTES = 8192;
    localparam int VRAM_AW    = $clog2(VRAM_BYTES);

    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    // Register index, taken from paddr[4:2]
    localparam logic [2:0] REG_LCD_CONTROL = 3'd0;
    localparam logic [2:0] REG_SCROLL_X    = 3'd1;
    localparam logic [2:0] REG_SCROLL_Y    = 3'd2;
    localparam logic [2:0] REG_WINDOW_X    = 3'd3;
    localparam logic [2:0] REG_WINDOW_Y    = 3'd4;

    // lcd_control bit positions
    localparam int LCDC_BG_MAP    = 3;
    localparam int LCDC_TILE_DATA = 4;
    localparam int LCDC_WIN_EN    = 5;
    localparam int LCDC_WIN_MAP   = 6;

    // Tile data base for signed tile numbers, relative to video memory start
    localparam logic [VRAM_AW-1:0] SIGNED_TILE_BASE = VRAM_AW'(16'h1000);
    // Upper bits common to both tile maps (0x1800 and 0x1C00)
    localparam logic [1:0] MAP_PREFIX = 2'b11;
    localparam logic [7:0] WINDOW_X_OFFSET = 8'd7;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LINE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        STEP_MAP  = 4'b0001,
        STEP_LOW  = 4'b0010,
        STEP_HIGH = 4'b0100,
        STEP_PUSH = 4'b1000
    } step_t;

    typedef struct packed {
        logic [7:0] lcd_control;
        logic [7:0] scroll_x;
        logic [7:0] scroll_y;
        logic [7:0] window_x;
        logic [7:0] window_y;
    } cfg_t;

endpackage

FILE: hw/rtl/btf_vram.sv
// Single-port video memory with registered read data.
module btf_vram (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [btf_pkg::VRAM_AW-1:0] addr,
    input  logic [7:0]                  wdata,
    output logic [7:0]                  rdata
);
    import btf_pkg::*;

    logic [7:0] ram_reg [VRAM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[addr] <= wdata;
        end
        rdata_reg <= ram_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/btf_cfg.sv
// APB register file: lcd control, scroll and window position.
module btf_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [btf_pkg::CFG_AW-1:0] paddr,
    input  logic [btf_pkg::CFG_DW-1:0] pwdata,
    output logic [btf_pkg::CFG_DW-1:0] prdata,
    output logic                       pready,
    output btf_pkg::cfg_t              cfg
);
    import btf_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;
    logic [7:0] rd_byte;

    assign idx   = paddr[CFG_AW-1:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_LCD_CONTROL: cfg_reg.lcd_control <= pwdata[7:0];
                REG_SCROLL_X:    cfg_reg.scroll_x    <= pwdata[7:0];
                REG_SCROLL_Y:    cfg_reg.scroll_y    <= pwdata[7:0];
                REG_WINDOW_X:    cfg_reg.window_x    <= pwdata[7:0];
                REG_WINDOW_Y:    cfg_reg.window_y    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LCD_CONTROL: rd_byte = cfg_reg.lcd_control;
            REG_SCROLL_X:    rd_byte = cfg_reg.scroll_x;
            REG_SCROLL_Y:    rd_byte = cfg_reg.scroll_y;
            REG_WINDOW_X:    rd_byte = cfg_reg.window_x;
            REG_WINDOW_Y:    rd_byte = cfg_reg.window_y;
            default:         rd_byte = 8'd0;
        endcase
    end

    assign prdata = {{(CFG_DW-8){1'b0}}, rd_byte};
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

FILE: hw/rtl/background_tile_fetcher.sv
// Top level of the background and window tile fetcher.
//
// The fetcher owns an 8 KiB video memory (offset 0 is console address 0x8000)
// that write transfers fill, and runs the four-step tile fetch on tick
// transfers: tile number from the background or window map, low bitplane,
// high bitplane, then a push of eight 2-bit colour indices once the
// downstream queue reports empty. A start-of-line transfer restarts the
// cycle at tile column zero. Every input transfer yields exactly one output
// transfer; a push carries push_valid = 1, anything else carries all zeros.
// Throughput is one item per clock while the skid stage is empty: each item
// makes at most one access to the single-port video memory, issued in the
// cycle of its transfer. The output is registered. A read result is
// forwarded from the memory output to the next item's address (tile number
// into the plane address) and into the pixel interleave (high plane into
// the push), so dependent steps follow back to back. An output register
// plus a skid stage keep s_tready independent of m_tready. Memory contents
// are not cleared by reset; entries read before being written return
// arbitrary data.
module background_tile_fetcher (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input channel
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // [12:0] address, [20:13] write_data, [28:21] line, [29] fifo_empty
    input  logic [31:0]                s_tdata,
    // [1:0] operation
    input  logic [1:0]                 s_tuser,
    // result channel
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [15:0] pixel_row
    output logic [15:0]                m_tdata,
    // [0] push_valid, [1] from_window
    output logic [1:0]                 m_tuser,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [btf_pkg::CFG_AW-1:0] paddr,
    input  logic [btf_pkg::CFG_DW-1:0] pwdata,
    output logic [btf_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);
    import btf_pkg::*;

    typedef struct packed {
        logic        from_window;
        logic [15:0] pixel_row;
        logic        push_valid;
    } res_t;

    cfg_t cfg;

    btf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Unpack the input transfer
    logic               accept;
    op_t                op;
    logic [VRAM_AW-1:0] in_address;
    logic [7:0]         in_write_data;
    logic [7:0]         in_line;
    logic               in_fifo_empty;

    assign accept        = s_tvalid && s_tready;
    assign op            = op_t'(s_tuser);
    assign in_address    = s_tdata[12:0];
    assign in_write_data = s_tdata[20:13];
    assign in_line       = s_tdata[28:21];
    assign in_fifo_empty = s_tdata[29];

    // Fetcher state
    step_t      step_reg, step_next;
    logic [5:0] tile_column_reg, tile_column_next;
    logic       window_active_reg, window_active_next;
    logic [7:0] tile_number_reg;
    logic [7:0] low_plane_reg;
    logic [7:0] high_plane_reg;
    // Which plane/tile register picks up the memory output this cycle
    logic       cap_tile_reg, cap_tile_next;
    logic       cap_low_reg, cap_low_next;
    logic       cap_high_reg, cap_high_next;

    logic [7:0] vram_rdata;
    logic       vram_we;
    logic [VRAM_AW-1:0] vram_addr;

    // Forward a read that is just coming out of memory
    logic [7:0] tile_eff;
    logic [7:0] high_eff;
    assign tile_eff = cap_tile_reg ? vram_rdata : tile_number_reg;
    assign high_eff = cap_high_reg ? vram_rdata : high_plane_reg;

    // Window start test on the column's left pixel
    logic [9:0] col_px_plus7;
    logic       window_hit;
    assign col_px_plus7 = {1'b0, tile_column_reg, 3'b000} + 10'd7;
    assign window_hit   = cfg.lcd_control[LCDC_WIN_EN]
                          && (cfg.window_y <= in_line)
                          && ({2'b00, cfg.window_x} <= col_px_plus7);

    // Map coordinates
    logic [7:0]         wx_minus7;
    logic [4:0]         win_col_ofs;
    logic [7:0]         win_dy;
    logic [7:0]         bg_y;
    logic [4:0]         map_x;
    logic [4:0]         map_y;
    logic               map_sel;
    logic [VRAM_AW-1:0] map_addr;

    assign wx_minus7   = cfg.window_x - WINDOW_X_OFFSET;
    assign win_col_ofs = (cfg.window_x >= WINDOW_X_OFFSET) ? wx_minus7[7:3] : 5'd0;
    assign win_dy      = in_line - cfg.window_y;
    assign bg_y        = in_line + cfg.scroll_y;

    always_comb begin
        if (window_hit) begin
            map_x   = tile_column_reg[4:0] - win_col_ofs;
            map_y   = win_dy[7:3];
            map_sel = cfg.lcd_control[LCDC_WIN_MAP];
        end else begin
            map_x   = cfg.scroll_x[7:3] + tile_column_reg[4:0];
            map_y   = bg_y[7:3];
            map_sel = cfg.lcd_control[LCDC_BG_MAP];
        end
    end

    assign map_addr = {MAP_PREFIX, map_sel, map_y, map_x};

    // Bitplane address: tile base, row within tile, plane select
    logic [VRAM_AW-1:0] tile_base;
    logic [2:0]         tile_row;
    logic               plane_sel;
    logic [VRAM_AW-1:0] plane_addr;

    assign tile_base = cfg.lcd_control[LCDC_TILE_DATA]
                       ? {1'b0, tile_eff, 4'b0000}
                       : SIGNED_TILE_BASE + {tile_eff[7], tile_eff, 4'b0000};
    assign tile_row  = window_active_reg ? win_dy[2:0] : bg_y[2:0];
    assign plane_sel = (step_reg == STEP_HIGH);
    assign plane_addr = {tile_base[VRAM_AW-1:4], tile_row, plane_sel};

    // Interleave planes: leftmost pixel (bit 7) in bits 15:14
    logic [15:0] pixels;
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            pixels[2*i]   = low_plane_reg[i];
            pixels[2*i+1] = high_eff[i];
        end
    end

    // Per-item control
    res_t res;

    always_comb begin
        step_next          = step_reg;
        tile_column_next   = tile_column_reg;
        window_active_next = window_active_reg;
        cap_tile_next      = 1'b0;
        cap_low_next       = 1'b0;
        cap_high_next      = 1'b0;
        vram_we            = 1'b0;
        vram_addr          = in_address;
        res                = '0;
        if (accept) begin
            case (op)
                OP_WRITE: begin
                    vram_we = 1'b1;
                end
                OP_LINE: begin
                    step_next          = STEP_MAP;
                    tile_column_next   = 6'd0;
                    window_active_next = 1'b0;
                end
                OP_TICK: begin
                    case (step_reg)
                        STEP_MAP: begin
                            window_active_next = window_hit;
                            vram_addr          = map_addr;
                            cap_tile_next      = 1'b1;
                            step_next          = STEP_LOW;
                        end
                        STEP_LOW: begin
                            vram_addr    = plane_addr;
                            cap_low_next = 1'b1;
                            step_next    = STEP_HIGH;
                        end
                        STEP_HIGH: begin
                            vram_addr     = plane_addr;
                            cap_high_next = 1'b1;
                            step_next     = STEP_PUSH;
                        end
                        STEP_PUSH: begin
                            // hold at this step until the queue drains
                            if (in_fifo_empty) begin
                                res.push_valid   = 1'b1;
                                res.pixel_row    = pixels;
                                res.from_window  = window_active_reg;
                                tile_column_next = tile_column_reg + 6'd1;
                                step_next        = STEP_MAP;
                            end
                        end
                        default: begin
                            step_next = STEP_MAP;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    btf_vram u_vram (
        .aclk  (aclk),
        .we    (vram_we),
        .addr  (vram_addr),
        .wdata (in_write_data),
        .rdata (vram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg          <= STEP_MAP;
            tile_column_reg   <= 6'd0;
            window_active_reg <= 1'b0;
            cap_tile_reg      <= 1'b0;
            cap_low_reg       <= 1'b0;
            cap_high_reg      <= 1'b0;
        end else begin
            step_reg          <= step_next;
            tile_column_reg   <= tile_column_next;
            window_active_reg <= window_active_next;
            cap_tile_reg      <= cap_tile_next;
            cap_low_reg       <= cap_low_next;
            cap_high_reg      <= cap_high_next;
        end
    end

    // Capture read data in the cycle after the access
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_number_reg <= 8'd0;
            low_plane_reg   <= 8'd0;
            high_plane_reg  <= 8'd0;
        end else begin
            if (cap_tile_reg) begin
                tile_number_reg <= vram_rdata;
            end
            if (cap_low_reg) begin
                low_plane_reg <= vram_rdata;
            end
            if (cap_high_reg) begin
                high_plane_reg <= vram_rdata;
            end
        end
    end

    // Output register with skid stage
    logic m_valid_reg;
    res_t out_reg;
    logic skid_valid_reg;
    res_t skid_reg;

    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg.pixel_row;
    assign m_tuser  = {out_reg.from_window, out_reg.push_valid};

endmodule
